FILE: rtl/i2ccds_pkg.sv
// Shared types and constants for the bus clock divider search.
// Used by i2ccds_divider and i2c_clock_divider_search; no dependencies.
`default_nettype none

package i2ccds_pkg;

   localparam int CLK_W     = 30;   // bus clock frequency field
   localparam int RATE_W    = 23;   // requested rate field
   localparam int M_W       = 4;    // mantissa field
   localparam int N_W       = 3;    // exponent field
   localparam int CCR_W     = M_W + N_W;
   localparam int DIVISOR_W = 8;    // 10 * (m + 1) stays below 256
   localparam int CNT_W     = $clog2(CLK_W + 1);

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam int M_MAX_DEFAULT = 15;
   localparam int N_MAX_DEFAULT = 7;

   localparam logic [M_W-1:0]   DEFAULT_M       = M_W'(5);
   localparam logic [N_W-1:0]   DEFAULT_N       = N_W'(0);
   localparam logic [CLK_W-1:0] BUS_CLOCK_RESET = CLK_W'(24000000);

   // register index, taken from the word address
   typedef enum logic {
      CSR_BUS_CLOCK = 1'b0,
      CSR_UNUSED    = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LAUNCH,
      ST_WAIT,
      ST_EVAL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                 start;
      logic [CLK_W-1:0]     dividend;
      logic [DIVISOR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [CLK_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

FILE: rtl/i2c_clock_divider_search.sv
// Top level of the bus clock divider search: sequencer, best-pair tracking, CSR port.
// Depends on i2ccds_pkg and instantiates i2ccds_divider.
//
//   channel   ports                                  handshake
//   request   start, busy, req_desired_rate          taken when start && !busy
//   result    rsp_valid, rsp_div_m/n, rsp_ccr_word,   one-cycle strobe
//             rsp_found
//   csr       psel, penable, pwrite, paddr, pwdata,  APB, pready tied high
//             prdata, pready
//
// Each of the (N_MAX+1)*(M_MAX+1) candidates is handled in turn: launch the
// serial divider, take CLK_W (30) quotient bits one per cycle, see done, compare.
// busy stays high through the cycle of rsp_valid and drops in the next. Reset
// is synchronous and needs no clearing pass; the result side cannot stall, so
// the result strobe is never held back.
`default_nettype none

module i2c_clock_divider_search #(
   parameter int M_MAX = i2ccds_pkg::M_MAX_DEFAULT,
   parameter int N_MAX = i2ccds_pkg::N_MAX_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output      logic                              busy,
   input  wire logic [i2ccds_pkg::RATE_W-1:0]     req_desired_rate,
   output      logic                              rsp_valid,
   output      logic [i2ccds_pkg::M_W-1:0]        rsp_div_m,
   output      logic [i2ccds_pkg::N_W-1:0]        rsp_div_n,
   output      logic [i2ccds_pkg::CCR_W-1:0]      rsp_ccr_word,
   output      logic                              rsp_found,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [i2ccds_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [i2ccds_pkg::CSR_DATA_W-1:0] pwdata,
   output      logic [i2ccds_pkg::CSR_DATA_W-1:0] prdata,
   output      logic                              pready
);
   import i2ccds_pkg::*;

   localparam logic [M_W-1:0] M_LAST = M_W'(M_MAX);
   localparam logic [N_W-1:0] N_LAST = N_W'(N_MAX);

   state_type            state_ff, state_in;

   logic [CLK_W-1:0]     clk_hz_ff, clk_hz_in;
   logic [RATE_W-1:0]    req_ff, req_in;
   logic [M_W-1:0]       m_ff, m_in;
   logic [N_W-1:0]       n_ff, n_in;
   logic [RATE_W-1:0]    best_ff, best_in;
   logic [M_W-1:0]       pick_m_ff, pick_m_in;
   logic [N_W-1:0]       pick_n_ff, pick_n_in;
   logic                 found_ff, found_in;

   logic                 load_req;
   logic                 launch;
   logic                 eval_en;
   logic                 last_pair;
   logic                 csr_write;
   csr_index_type        csr_index;

   logic [M_W:0]         m_plus;
   logic [DIVISOR_W-1:0] divisor;
   logic [CLK_W-1:0]     rate;
   logic                 fits;
   logic [RATE_W-1:0]    shortfall;
   logic                 better;

   div_req_type          div_req;
   div_rsp_type          div_rsp;

   i2ccds_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // CSR port
   always_comb begin
      pready    = 1'b1;
      csr_index = csr_index_type'(paddr[2]);
      csr_write = psel && penable && pwrite && pready;
      clk_hz_in = clk_hz_ff;
      if (csr_write && csr_index == CSR_BUS_CLOCK) begin
         clk_hz_in = pwdata[CLK_W-1:0];
      end
      case (csr_index)
         CSR_BUS_CLOCK: prdata = {{(CSR_DATA_W - CLK_W){1'b0}}, clk_hz_ff};
         default:       prdata = '0;
      endcase
   end

   // divisor 10*(m+1) = 8*(m+1) + 2*(m+1)
   always_comb begin
      m_plus  = {1'b0, m_ff} + (M_W + 1)'(1);
      divisor = (DIVISOR_W'(m_plus) << 3) + (DIVISOR_W'(m_plus) << 1);
      div_req.start    = launch;
      div_req.dividend = clk_hz_ff;
      div_req.divisor  = divisor;
   end

   // clk/(10(m+1)*2^n) equals the quotient for 10(m+1) shifted right by n
   always_comb begin
      rate      = div_rsp.quotient >> n_ff;
      fits      = {{(CLK_W - RATE_W){1'b0}}, req_ff} >= rate;
      shortfall = req_ff - rate[RATE_W-1:0];
      better    = fits && (!found_ff || shortfall < best_ff);
      last_pair = (m_ff == M_LAST) && (n_ff == N_LAST);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (start) state_in = ST_LAUNCH;
         ST_LAUNCH: state_in = ST_WAIT;
         ST_WAIT:   if (div_rsp.done) state_in = ST_EVAL;
         ST_EVAL:   state_in = last_pair ? ST_DONE : ST_LAUNCH;
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      load_req  = 1'b0;
      launch    = 1'b0;
      eval_en   = 1'b0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            load_req = start;
         end
         ST_LAUNCH: launch    = 1'b1;
         ST_EVAL:   eval_en   = 1'b1;
         ST_DONE:   rsp_valid = 1'b1;
         default:   busy      = 1'b1;
      endcase
   end

   // search datapath
   always_comb begin
      req_in    = req_ff;
      m_in      = m_ff;
      n_in      = n_ff;
      best_in   = best_ff;
      pick_m_in = pick_m_ff;
      pick_n_in = pick_n_ff;
      found_in  = found_ff;
      if (load_req) begin
         req_in    = req_desired_rate;
         m_in      = '0;
         n_in      = '0;
         pick_m_in = DEFAULT_M;
         pick_n_in = DEFAULT_N;
         found_in  = 1'b0;
      end else if (eval_en) begin
         if (better) begin
            best_in   = shortfall;
            pick_m_in = m_ff;
            pick_n_in = n_ff;
            found_in  = 1'b1;
         end
         // advance mantissa first, exponent on wrap
         if (m_ff == M_LAST) begin
            m_in = '0;
            n_in = n_ff + N_W'(1);
         end else begin
            m_in = m_ff + M_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         clk_hz_ff <= BUS_CLOCK_RESET;
         found_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clk_hz_ff <= clk_hz_in;
         found_ff  <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      m_ff      <= m_in;
      n_ff      <= n_in;
      best_ff   <= best_in;
      pick_m_ff <= pick_m_in;
      pick_n_ff <= pick_n_in;
   end

   always_comb begin
      rsp_div_m    = pick_m_ff;
      rsp_div_n    = pick_n_ff;
      rsp_ccr_word = {pick_m_ff, pick_n_ff};
      rsp_found    = found_ff;
   end

   a_start_sets_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request transfer did not make the block busy");

   a_result_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("block still busy after its result transfer");

   a_default_pair: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_div_m == DEFAULT_M && rsp_div_n == DEFAULT_N))
      else $error("no qualifying pair but result is not the default divider");

   a_eval_after_div: assert property (@(posedge clock) disable iff (reset)
      eval_en |-> $past(div_rsp.done))
      else $error("candidate compared before its division finished");

   a_launch_idle_div: assert property (@(posedge clock) disable iff (reset)
      launch |-> !div_rsp.busy)
      else $error("divider launched while still running");

endmodule

`default_nettype wire

FILE: rtl/i2ccds_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on i2ccds_pkg for widths and the request/response structs.
`default_nettype none

module i2ccds_divider (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire i2ccds_pkg::div_req_type  div_req,
   output i2ccds_pkg::div_rsp_type       div_rsp
);
   import i2ccds_pkg::*;

   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CLK_W - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [CLK_W-1:0]     quo_ff, quo_in;
   logic [DIVISOR_W-1:0] divisor_ff, divisor_in;

   logic [DIVISOR_W:0]   rem_shift;
   logic [DIVISOR_W:0]   rem_diff;
   logic                 fits;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[CLK_W-1]};
      rem_diff  = rem_shift - {1'b0, divisor_ff};
      fits      = rem_shift >= {1'b0, divisor_ff};
   end

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (!busy_ff && div_req.start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         rem_in     = '0;
         quo_in     = div_req.dividend;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         // shift the next dividend bit in, subtract where it fits
         rem_in   = fits ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
         quo_in   = {quo_ff[CLK_W-2:0], fits};
         count_in = count_ff + CNT_W'(1);
         if (count_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff   <= count_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   always_comb begin
      div_rsp.busy     = busy_ff;
      div_rsp.done     = done_ff;
      div_rsp.quotient = quo_ff;
   end

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a running division");

   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider still busy while reporting done");

   a_start_taken: assert property (@(posedge clock) disable iff (reset)
      (div_req.start && !busy_ff) |=> busy_ff)
      else $error("divider ignored a start while idle");

endmodule

`default_nettype wire
